@@ hdl/rqs_pkg.sv @@
package rqs_pkg;

  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_TICK       = 3'd2;
  localparam logic [2:0] MODE_POP_RATIO  = 3'd3;
  localparam logic [2:0] MODE_POP_SHORT  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] burst;
    logic [15:0] wait_t;
  } task_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_RD,
    S_TICK_WR,
    S_SCAN_RD,
    S_SCAN_MUL,
    S_SCAN_CMP,
    S_SHIFT_SET,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic finish;
    logic rd_cur;
    logic rd_next;
    logic tick_wr;
    logic mul;
    logic cmp;
    logic shift_wr;
    logic idx_inc;
    logic idx_best;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic op_pop;
    logic empty;
    logic last;
    logic shift_end;
  } sts_t;

endpackage

@@ hdl/ready_queue_hrrn_sjf_select.sv @@
// Push: decode, finish. Tick: read and write back each task. Pop: scan all, then compact.
// Empty pops, full pushes and unused modes go from decode straight to finish.
// Throughput: one word at a time; the next is taken in the cycle after its result is
// registered. The pop scan shares one memory read port and one cross-multiply compare.
// Reset (rst_n, synchronous, active low) empties the queue; slot contents are not cleared.
module ready_queue_hrrn_sjf_select #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_task_pid,
  input  logic [15:0] in_burst_time,
  input  logic [15:0] in_wait_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_pid,
  output logic [15:0] out_burst,
  output logic [15:0] out_wait,
  output logic [4:0]  out_occupancy
);
  import rqs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rqs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_task_pid   (in_task_pid),
    .in_burst_time (in_burst_time),
    .in_wait_time  (in_wait_time),
    .out_status    (out_status),
    .out_pid       (out_pid),
    .out_burst     (out_burst),
    .out_wait      (out_wait),
    .out_occupancy (out_occupancy)
  );

endmodule

@@ hdl/rqs_ctrl.sv @@
module rqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rqs_pkg::sts_t sts,
  output rqs_pkg::cmd_t cmd
);
  import rqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op_tick && !sts.empty) begin
          state_nxt = S_TICK_RD;
        end else if (sts.op_pop && !sts.empty) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TICK_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_TICK_WR;
      end
      S_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = sts.last ? S_FIN : S_TICK_RD;
      end
      S_SCAN_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_SCAN_MUL;
      end
      S_SCAN_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.cmp     = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = sts.last ? S_SHIFT_SET : S_SCAN_RD;
      end
      S_SHIFT_SET: begin
        cmd.idx_best = 1'b1;
        state_nxt    = S_SHIFT_CHK;
      end
      S_SHIFT_CHK: begin
        if (sts.shift_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SHIFT_CHK;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/rqs_dpath.sv @@
module rqs_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rqs_pkg::cmd_t cmd,
  output rqs_pkg::sts_t sts,
  input  logic [2:0]    in_mode,
  input  logic [15:0]   in_task_pid,
  input  logic [15:0]   in_burst_time,
  input  logic [15:0]   in_wait_time,
  output logic [1:0]    out_status,
  output logic [15:0]   out_pid,
  output logic [15:0]   out_burst,
  output logic [15:0]   out_wait,
  output logic [4:0]    out_occupancy
);
  import rqs_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

  task_t          mem [QUEUE_DEPTH];
  logic [2:0]     op_r;
  task_t          in_r;
  task_t          rd_data_r;
  task_t          cand_r;
  task_t          best_r;
  logic [AW-1:0]  best_idx_r;
  logic [31:0]    prod_c_r, prod_b_r;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  k_r;
  logic [CW-1:0]  k_p1;
  logic [AW-1:0]  k_lo, k1_lo;
  logic [1:0]     out_status_r;
  task_t          out_task_r;
  logic [4:0]     out_occ_r;

  logic           op_push, op_front, full, pop_ok, push_ok;
  logic [1:0]     res_status;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  task_t          wdata;
  logic [15:0]    nb_cand, nb_best;
  logic           better;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  assign k_lo     = k_r[AW-1:0];
  assign k_p1     = k_r + CW'(1);
  assign k1_lo    = k_lo + AW'(1);
  assign op_push  = (op_r == MODE_PUSH_BACK) || (op_r == MODE_PUSH_FRONT);
  assign op_front = (op_r == MODE_PUSH_FRONT);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign push_ok  = op_push && !full;
  assign pop_ok   = sts.op_pop && !sts.empty;

  assign sts.op_tick   = (op_r == MODE_TICK);
  assign sts.op_pop    = (op_r == MODE_POP_RATIO) || (op_r == MODE_POP_SHORT);
  assign sts.empty     = (count_r == '0);
  assign sts.last      = (k_p1 == count_r);
  assign sts.shift_end = (k_p1 >= count_r);

  always_comb begin
    if (op_push && full) res_status = ST_FULL;
    else if (sts.op_pop && sts.empty) res_status = ST_EMPTY;
    else res_status = ST_DONE;
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.finish && push_ok) begin
      count_nxt = count_r + CW'(1);
      if (op_front) head_nxt = (head_r == '0) ? AW'(QUEUE_DEPTH - 1) : head_r - AW'(1);
    end else if (cmd.finish && pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // single write port: push, tick update or compaction
  always_comb begin
    we    = 1'b0;
    waddr = phys(head_r, k_lo);
    wdata = rd_data_r;
    if (cmd.finish && push_ok) begin
      we    = 1'b1;
      wdata = in_r;
      waddr = op_front ? head_nxt : phys(head_r, count_r[AW-1:0]);
    end else if (cmd.tick_wr) begin
      we = 1'b1;
      if (rd_data_r.wait_t != WAIT_MAX) wdata.wait_t = rd_data_r.wait_t + 16'd1;
    end else if (cmd.shift_wr) begin
      we = 1'b1;
    end
  end

  assign raddr = cmd.rd_next ? phys(head_r, k1_lo) : phys(head_r, k_lo);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_cur || cmd.rd_next) rd_data_r <= mem[raddr];
  end

  assign nb_cand = (rd_data_r.burst == '0) ? 16'd1 : rd_data_r.burst;
  assign nb_best = (best_r.burst == '0) ? 16'd1 : best_r.burst;

  always_comb begin
    if (op_r == MODE_POP_RATIO) better = prod_c_r > prod_b_r;
    else better = cand_r.burst < best_r.burst;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r.pid    <= in_task_pid;
      in_r.burst  <= in_burst_time;
      in_r.wait_t <= in_wait_time;
    end
    if (cmd.mul) begin
      cand_r   <= rd_data_r;
      prod_c_r <= rd_data_r.wait_t * nb_best;
      prod_b_r <= best_r.wait_t * nb_cand;
    end
    if (cmd.cmp && (k_r == '0 || better)) begin
      best_r     <= cand_r;
      best_idx_r <= k_lo;
    end
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_task_r   <= pop_ok ? best_r : '0;
      out_occ_r    <= 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= MODE_PUSH_BACK;
      head_r  <= '0;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cmd.load_in) begin
        op_r <= in_mode;
        k_r  <= '0;
      end else if (cmd.idx_best) begin
        k_r <= CW'(best_idx_r);
      end else if (cmd.idx_inc) begin
        k_r <= k_p1;
      end
    end
  end

  assign out_status    = out_status_r;
  assign out_pid       = out_task_r.pid;
  assign out_burst     = out_task_r.burst;
  assign out_wait      = out_task_r.wait_t;
  assign out_occupancy = out_occ_r;

endmodule
